@@ src/format_string_printer_top_defines.svh @@
// ============================================================================
// format string printer assertion macros
// shared concurrent assertion shorthands, clocked on clk, disabled in reset
// ============================================================================
`ifndef FORMAT_STRING_PRINTER_TOP_DEFINES_SVH
`define FORMAT_STRING_PRINTER_TOP_DEFINES_SVH

// same-cycle implication
`define FSP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsp assertion failed");

// next-cycle implication
`define FSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsp assertion failed");

`endif

@@ src/fsp_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// fsp_pkg
// shared types, character codes and command/status structs
// ============================================================================
package fsp_pkg;

    localparam int BufDepth = 20;
    localparam int PtrW     = $clog2(BufDepth);
    localparam int ArgW     = 64;
    localparam int WidthW   = 6;
    localparam int IterW    = $clog2(ArgW);
    localparam int CfgIdxW  = 2;

    // register indexes
    localparam logic [CfgIdxW-1:0] RegHexUpper    = 2'd0;
    localparam logic [CfgIdxW-1:0] RegAcceptUpper = 2'd1;

    // character codes
    localparam logic [7:0] ChNul     = 8'h00;
    localparam logic [7:0] ChPercent = "%";
    localparam logic [7:0] ChZero    = "0";
    localparam logic [7:0] ChNine    = "9";
    localparam logic [7:0] ChSpace   = " ";
    localparam logic [7:0] ChMinus   = "-";
    localparam logic [7:0] ChLowL    = "l";
    localparam logic [7:0] ChUpL     = "L";
    localparam logic [7:0] ChUpA     = "A";
    localparam logic [7:0] ChUpZ     = "Z";
    localparam logic [7:0] ChLowC    = "c";
    localparam logic [7:0] ChLowS    = "s";
    localparam logic [7:0] ChLowD    = "d";
    localparam logic [7:0] ChLowI    = "i";
    localparam logic [7:0] ChLowU    = "u";
    localparam logic [7:0] ChLowX    = "x";

    localparam logic [7:0] CaseOffset      = 8'h20;
    localparam logic [7:0] HexLetterOffset = 8'd39;  // 'a' - '9' - 1

    // conversion kinds
    localparam logic [2:0] ConvEcho = 3'd0;
    localparam logic [2:0] ConvChar = 3'd1;
    localparam logic [2:0] ConvNone = 3'd2;
    localparam logic [2:0] ConvSdec = 3'd3;
    localparam logic [2:0] ConvUdec = 3'd4;
    localparam logic [2:0] ConvHex  = 3'd5;

    // output character select
    localparam logic [1:0] SelChar  = 2'd0;
    localparam logic [1:0] SelMinus = 2'd1;
    localparam logic [1:0] SelFill  = 2'd2;
    localparam logic [1:0] SelDigit = 2'd3;

    typedef struct packed {
        logic       is_zero;
        logic       is_pct;
        logic       is_fill;
        logic       is_digit;
        logic       is_lmod;
        logic       is_low_l;
        logic [2:0] conv;
    } cls_t;

    typedef struct packed {
        logic       latch_char;
        logic       char_from_arg;
        logic       clear_spec;
        logic       set_fill;
        logic       upd_width;
        logic       set_ll;
        logic       load_num;
        logic       num_signed;
        logic       num_hex;
        logic       dabble;
        logic       scan_dec;
        logic       load_pad;
        logic       pad_dec;
        logic       ptr_dec;
        logic       out_load;
        logic       out_last;
        logic [1:0] out_sel;
    } cmd_t;

    typedef struct packed {
        cls_t cls;
        logic neg;
        logic conv_done;
        logic scan_done;
        logic pad_zero;
        logic ptr_zero;
        logic slot_free;
    } sts_t;

endpackage

@@ src/fsp_ifs.sv @@
`timescale 1ns / 1ps
// ============================================================================
// fsp channel interfaces
// format input, character output and configuration write channels
// ============================================================================
interface fsp_fmt_if;
    logic        valid;
    logic        ready;
    logic [7:0]  fmt_byte;
    logic [63:0] argument;

    modport source (output valid, output fmt_byte, output argument, input ready);
    modport sink (input valid, input fmt_byte, input argument, output ready);
endinterface

interface fsp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink (input valid, input out_char, input last, output ready);
endinterface

interface fsp_cfg_if;
    import fsp_pkg::*;
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic               data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/fsp_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// fsp_ctrl
// format parser phase and conversion/emit sequencer
// ============================================================================
module fsp_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  fsp_pkg::sts_t sts,
    output fsp_pkg::cmd_t cmd
);
    import fsp_pkg::*;

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StChar  = 3'd1;
    localparam logic [2:0] StSign  = 3'd2;
    localparam logic [2:0] StConv  = 3'd3;
    localparam logic [2:0] StScan  = 3'd4;
    localparam logic [2:0] StPad   = 3'd5;
    localparam logic [2:0] StDigit = 3'd6;

    localparam logic [2:0] PhLiteral = 3'd0;
    localparam logic [2:0] PhPercent = 3'd1;
    localparam logic [2:0] PhWidth   = 3'd2;
    localparam logic [2:0] PhLong1   = 3'd3;
    localparam logic [2:0] PhLong2   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic       do_mod;
    logic       do_conv;

    assign in_ready = (state_reg == StIdle);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        do_mod     = 1'b0;
        do_conv    = 1'b0;
        case (state_reg)
            StIdle:
            begin
                if (in_valid)
                begin
                    if (sts.cls.is_zero)
                    begin
                        phase_next = PhLiteral;
                    end
                    else
                    begin
                        case (phase_reg)
                            PhPercent:
                            begin
                                if (sts.cls.is_fill)
                                begin
                                    cmd.set_fill = 1'b1;
                                    phase_next   = PhWidth;
                                end
                                else
                                begin
                                    do_mod = 1'b1;
                                end
                            end
                            PhWidth:
                            begin
                                if (sts.cls.is_digit)
                                    cmd.upd_width = 1'b1;
                                else
                                    do_mod = 1'b1;
                            end
                            PhLong1:
                            begin
                                if (sts.cls.is_low_l)
                                begin
                                    cmd.set_ll = 1'b1;
                                    phase_next = PhLong2;
                                end
                                else
                                begin
                                    do_conv = 1'b1;
                                end
                            end
                            PhLong2:
                            begin
                                do_conv = 1'b1;
                            end
                            default:
                            begin
                                phase_next = PhLiteral;
                                if (sts.cls.is_pct)
                                begin
                                    // spec registers start clean for the new spec
                                    cmd.clear_spec = 1'b1;
                                    phase_next     = PhPercent;
                                end
                                else
                                begin
                                    cmd.latch_char = 1'b1;
                                    state_next     = StChar;
                                end
                            end
                        endcase

                        if (do_mod)
                        begin
                            if (sts.cls.is_lmod)
                                phase_next = PhLong1;
                            else
                                do_conv = 1'b1;
                        end

                        if (do_conv)
                        begin
                            phase_next = PhLiteral;
                            case (sts.cls.conv)
                                ConvChar:
                                begin
                                    cmd.latch_char    = 1'b1;
                                    cmd.char_from_arg = 1'b1;
                                    state_next        = StChar;
                                end
                                ConvNone:
                                begin
                                    state_next = StIdle;
                                end
                                ConvSdec:
                                begin
                                    cmd.load_num   = 1'b1;
                                    cmd.num_signed = 1'b1;
                                    state_next     = sts.neg ? StSign : StConv;
                                end
                                ConvUdec:
                                begin
                                    cmd.load_num = 1'b1;
                                    state_next   = StConv;
                                end
                                ConvHex:
                                begin
                                    cmd.load_num = 1'b1;
                                    cmd.num_hex  = 1'b1;
                                    state_next   = StScan;
                                end
                                default:
                                begin
                                    cmd.latch_char = 1'b1;
                                    state_next     = StChar;
                                end
                            endcase
                        end
                    end
                end
            end
            StChar:
            begin
                if (sts.slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SelChar;
                    cmd.out_last = 1'b1;
                    state_next   = StIdle;
                end
            end
            StSign:
            begin
                if (sts.slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SelMinus;
                    state_next   = StConv;
                end
            end
            StConv:
            begin
                cmd.dabble = 1'b1;
                if (sts.conv_done)
                    state_next = StScan;
            end
            StScan:
            begin
                if (sts.scan_done)
                begin
                    cmd.load_pad = 1'b1;
                    state_next   = StPad;
                end
                else
                begin
                    cmd.scan_dec = 1'b1;
                end
            end
            StPad:
            begin
                if (sts.pad_zero)
                begin
                    state_next = StDigit;
                end
                else if (sts.slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SelFill;
                    cmd.pad_dec  = 1'b1;
                end
            end
            StDigit:
            begin
                if (sts.slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SelDigit;
                    cmd.out_last = sts.ptr_zero;
                    if (sts.ptr_zero)
                        state_next = StIdle;
                    else
                        cmd.ptr_dec = 1'b1;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            phase_reg <= PhLiteral;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

@@ src/fsp_datapath.sv @@
`timescale 1ns / 1ps
// ============================================================================
// fsp_datapath
// byte decode, spec registers, binary-to-decimal shifter, digit store, output
// ============================================================================
module fsp_datapath
#(
    parameter int unsigned MAX_WIDTH = 63
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [7:0]                  fmt_byte,
    input  logic [63:0]                 argument,
    input  logic                        cfg_we,
    input  logic [fsp_pkg::CfgIdxW-1:0] cfg_index,
    input  logic                        cfg_data,
    input  fsp_pkg::cmd_t               cmd,
    output fsp_pkg::sts_t               sts,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_char,
    output logic                        out_last
);
    import fsp_pkg::*;

    localparam logic [9:0]        MaxWidth = 10'(MAX_WIDTH);
    localparam logic [PtrW-1:0]   PtrTop   = PtrW'(BufDepth - 1);
    localparam logic [IterW-1:0]  IterLast = IterW'(ArgW - 1);

    logic              hex_upper_reg;
    logic              acc_upper_reg;
    logic [7:0]        fill_reg;
    logic [WidthW-1:0] width_reg;
    logic              ll_reg;
    logic [7:0]        char_reg;
    logic [ArgW-1:0]   mag_reg;
    logic [3:0]        digit_reg [BufDepth];
    logic [IterW-1:0]  iter_reg;
    logic [PtrW-1:0]   ptr_reg;
    logic [WidthW-1:0] pad_reg;
    logic              out_valid_reg;
    logic [7:0]        out_char_reg;
    logic              out_last_reg;

    cls_t              cls;
    logic [7:0]        lower;
    logic              neg;
    logic [ArgW-1:0]   num_src;
    logic [ArgW-1:0]   num_val;
    logic [3:0]        adj [BufDepth];
    logic [3:0]        dab [BufDepth];
    logic [9:0]        width_sum;
    logic [WidthW-1:0] width_next;
    logic [WidthW-1:0] digit_cnt;
    logic [WidthW-1:0] pad_next;
    logic [3:0]        cur_digit;
    logic [7:0]        digit_char;
    logic [7:0]        sel_char;
    logic              slot_free;

    // byte classification
    always_comb
    begin
        if (acc_upper_reg && (fmt_byte inside {[ChUpA:ChUpZ]}))
            lower = fmt_byte + CaseOffset;
        else
            lower = fmt_byte;

        cls.is_zero  = (fmt_byte == ChNul);
        cls.is_pct   = (fmt_byte == ChPercent);
        cls.is_fill  = (fmt_byte inside {ChZero, ChSpace});
        cls.is_digit = (fmt_byte inside {[ChZero:ChNine]});
        cls.is_lmod  = (fmt_byte == ChLowL) || (acc_upper_reg && (fmt_byte == ChUpL));
        cls.is_low_l = (fmt_byte == ChLowL);
        case (lower)
            ChLowC:         cls.conv = ConvChar;
            ChLowS:         cls.conv = ConvNone;
            ChLowD, ChLowI: cls.conv = ConvSdec;
            ChLowU:         cls.conv = ConvUdec;
            ChLowX:         cls.conv = ConvHex;
            default:        cls.conv = ConvEcho;
        endcase
    end

    // argument selection; the long flag was cleared when the spec opened
    assign neg = ll_reg ? argument[ArgW-1] : argument[31];

    always_comb
    begin
        if (ll_reg)
            num_src = argument;
        else if (cmd.num_signed)
            num_src = {{32{argument[31]}}, argument[31:0]};
        else
            num_src = {32'd0, argument[31:0]};

        if (cmd.num_signed && neg)
            num_val = '0 - num_src;
        else
            num_val = num_src;
    end

    // shift-add-3 step over all decimal digits
    always_comb
    begin
        for (int i = 0; i < BufDepth; i++)
        begin
            adj[i] = (digit_reg[i] >= 4'd5) ? (digit_reg[i] + 4'd3) : digit_reg[i];
        end
        dab[0] = {adj[0][2:0], mag_reg[ArgW-1]};
        for (int i = 1; i < BufDepth; i++)
        begin
            dab[i] = {adj[i][2:0], adj[i-1][3]};
        end
    end

    // width accumulate with saturation
    always_comb
    begin
        width_sum = 10'(width_reg) * 10'd10 + 10'(fmt_byte[3:0]);
        if (width_sum > MaxWidth)
            width_next = WidthW'(MaxWidth);
        else
            width_next = width_sum[WidthW-1:0];
    end

    assign digit_cnt = WidthW'(ptr_reg) + WidthW'(1);
    assign pad_next  = (width_reg > digit_cnt) ? (width_reg - digit_cnt) : '0;

    // digit to ascii
    assign cur_digit = digit_reg[ptr_reg];

    always_comb
    begin
        digit_char = {4'd0, cur_digit} + ChZero;
        if (digit_char > ChNine)
        begin
            digit_char = digit_char + HexLetterOffset;
            if (hex_upper_reg)
                digit_char = digit_char - CaseOffset;
        end
    end

    always_comb
    begin
        case (cmd.out_sel)
            SelChar:  sel_char = char_reg;
            SelMinus: sel_char = ChMinus;
            SelFill:  sel_char = fill_reg;
            SelDigit: sel_char = digit_char;
            default:  sel_char = char_reg;
        endcase
    end

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        sts.cls       = cls;
        sts.neg       = neg;
        sts.conv_done = (iter_reg == IterLast);
        sts.scan_done = (ptr_reg == '0) || (cur_digit != 4'd0);
        sts.pad_zero  = (pad_reg == '0);
        sts.ptr_zero  = (ptr_reg == '0);
        sts.slot_free = slot_free;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hex_upper_reg <= 1'b1;
            acc_upper_reg <= 1'b1;
            fill_reg      <= '0;
            width_reg     <= '0;
            ll_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == RegHexUpper))
                hex_upper_reg <= cfg_data;
            if (cfg_we && (cfg_index == RegAcceptUpper))
                acc_upper_reg <= cfg_data;

            if (cmd.clear_spec)
            begin
                fill_reg  <= '0;
                width_reg <= '0;
                ll_reg    <= 1'b0;
            end
            if (cmd.set_fill)
                fill_reg <= fmt_byte;
            if (cmd.upd_width)
                width_reg <= width_next;
            if (cmd.set_ll)
                ll_reg <= 1'b1;

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_char)
            char_reg <= cmd.char_from_arg ? argument[7:0] : fmt_byte;

        if (cmd.load_num)
        begin
            mag_reg  <= num_val;
            iter_reg <= '0;
            ptr_reg  <= PtrTop;
            // hex nibbles go straight into the digit store, decimal starts clear
            for (int i = 0; i < ArgW / 4; i++)
            begin
                digit_reg[i] <= cmd.num_hex ? num_val[4*i +: 4] : 4'd0;
            end
            for (int i = ArgW / 4; i < BufDepth; i++)
            begin
                digit_reg[i] <= 4'd0;
            end
        end
        else if (cmd.dabble)
        begin
            mag_reg  <= {mag_reg[ArgW-2:0], 1'b0};
            iter_reg <= iter_reg + IterW'(1);
            for (int i = 0; i < BufDepth; i++)
            begin
                digit_reg[i] <= dab[i];
            end
        end

        if (cmd.scan_dec || cmd.ptr_dec)
            ptr_reg <= ptr_reg - PtrW'(1);

        if (cmd.load_pad)
            pad_reg <= pad_next;
        else if (cmd.pad_dec)
            pad_reg <= pad_reg - WidthW'(1);

        if (cmd.out_load)
        begin
            out_char_reg <= sel_char;
            out_last_reg <= cmd.out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

@@ src/format_string_printer_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// format_string_printer_top
// printf-style engine: format bytes with arguments in, printed characters out
// ============================================================================
//
//  channel | dir | payload              | transaction
//  --------+-----+----------------------+------------------------------------
//  fmt     | in  | fmt_byte, argument   | one format byte with its argument
//  chars   | out | out_char, last       | one printed character
//  cfg     | in  | index, data          | one register write, always ready
//
//  input: one format byte is taken per transaction while the sequencer is
//    idle; a byte that prints nothing frees the input on the next cycle, a
//    single printed character holds it until the output register takes it
//  decimal conversions run a shift-add-3 converter over all 64 argument bits,
//    then a leading-zero scan of the digit store, then the fill and digit
//    characters, one per cycle while the one-character output register has
//    room; a minus sign goes out ahead of the converter; hex skips the converter
//  reset: asynchronous, active low; no clearing pass, ready right after reset
//  stalls: a full output register blocks only the next character; the input
//    is taken again as soon as the last character sits in the output register
//
module format_string_printer_top
#(
    parameter int unsigned MAX_WIDTH = 63
)
(
    input  logic        clk,
    input  logic        rst_n,
    fsp_fmt_if.sink     fmt,
    fsp_char_if.source  chars,
    fsp_cfg_if.sink     cfg
);
    import fsp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // registers are plain flops, writes never stall
    assign cfg.ready = 1'b1;

    // parser phase and emit sequencing
    fsp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (fmt.valid),
        .in_ready (fmt.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // spec registers, number converter, digit store and output register
    fsp_datapath
    #(
        .MAX_WIDTH (MAX_WIDTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fmt_byte  (fmt.fmt_byte),
        .argument  (fmt.argument),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (chars.valid),
        .out_ready (chars.ready),
        .out_char  (chars.out_char),
        .out_last  (chars.last)
    );

endmodule

@@ src/fsp_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// fsp_checker
// port-level checks on the format string printer, bound to the top level
// ============================================================================
`include "format_string_printer_top_defines.svh"

module fsp_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] in_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       out_last
);
    import fsp_pkg::*;

    // output held while stalled
    `FSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `FSP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_char) && $stable(out_last))
    // more characters of the same item still pending, so no new byte is taken
    `FSP_ASSERT_IMPLY(a_busy_mid_item, out_valid && !out_last, !in_ready)
    // a terminating zero prints nothing and leaves the input open
    `FSP_ASSERT_NEXT(a_nul_no_stall, in_valid && in_ready && (in_byte == ChNul), in_ready)

endmodule

bind format_string_printer_top fsp_checker u_fsp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fmt.valid),
    .in_ready  (fmt.ready),
    .in_byte   (fmt.fmt_byte),
    .out_valid (chars.valid),
    .out_ready (chars.ready),
    .out_char  (chars.out_char),
    .out_last  (chars.last)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// format string printer testbench
// feeds format bytes with arguments through the fmt channel, predicts every
// printed character with an in-bench printf engine and checks the chars
// channel in order; covers literals, all conversions, fill and width, length
// prefixes, register settings, random idling and a long output stall
// ============================================================================
module testbench;
    import fsp_pkg::*;

    // parser phases of the in-bench printf engine
    typedef enum logic [2:0] {
        PhLiteral,
        PhPercent,
        PhWidth,
        PhLong1,
        PhLong2
    } spec_phase_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } printed_char_t;

    localparam int MaxFieldWidth = 63;
    localparam int SettleCycles  = 200;    // longer than one decimal conversion
    localparam int DrainLimit    = 50000;

    logic clk;
    logic rst_n;

    fsp_fmt_if  fmt_ch ();
    fsp_char_if char_ch ();
    fsp_cfg_if  cfg_ch ();

    format_string_printer_top #(
        .MAX_WIDTH(MaxFieldWidth)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .fmt  (fmt_ch),
        .chars(char_ch),
        .cfg  (cfg_ch)
    );

    // printer state as the engine sees it
    spec_phase_t spec_phase;
    logic [7:0]  fill_q;
    int          width_q;
    logic        long_long_q;
    logic        hex_upper_q;
    logic        accept_upper_q;

    printed_char_t expected_chars[$];
    printed_char_t oldest_char;

    int mismatch_count;
    int items_sent;
    int idle_pct;
    int stall_pct;
    int hold_left;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // printf engine prediction
    // ------------------------------------------------------------------------
    function automatic void push_char(input logic [7:0] ch);
        printed_char_t pc;
        pc.ch   = ch;
        pc.last = 1'b0;
        expected_chars.push_back(pc);
    endfunction

    // fill to the field width, then digits most significant first
    function automatic void print_number(input logic [63:0] mag, input logic is_hex);
        logic [7:0] digits[$];
        logic [7:0] ch;
        int         pad;
        do
        begin
            if (is_hex)
            begin
                ch  = ChZero + 8'(mag[3:0]);
                mag = mag >> 4;
            end
            else
            begin
                ch  = ChZero + 8'(mag % 64'd10);
                mag = mag / 64'd10;
            end
            if (ch > ChNine)
            begin
                ch = ch + HexLetterOffset;
                if (hex_upper_q)
                    ch = ch - CaseOffset;
            end
            digits.push_front(ch);
        end
        while (mag != 64'd0);
        pad = (width_q > digits.size()) ? width_q - digits.size() : 0;
        repeat (pad) push_char(fill_q);
        foreach (digits[k])
            push_char(digits[k]);
    endfunction

    function automatic void convert_spec(input logic [7:0] b, input logic [63:0] arg);
        logic [7:0]  conv;
        logic [63:0] val;
        conv = b;
        if (accept_upper_q && b >= ChUpA && b <= ChUpZ)
            conv = b + CaseOffset;
        spec_phase = PhLiteral;
        if (conv == ChLowC)
            push_char(arg[7:0]);
        else if (conv == ChLowS)
            ;   // string conversion prints nothing
        else if (conv == ChLowD || conv == ChLowI)
        begin
            val = long_long_q ? arg : {{32{arg[31]}}, arg[31:0]};
            // sign goes out ahead of the padding
            if (val[63])
            begin
                push_char(ChMinus);
                val = -val;
            end
            print_number(val, 1'b0);
        end
        else if (conv == ChLowU || conv == ChLowX)
            print_number(long_long_q ? arg : {32'd0, arg[31:0]}, conv == ChLowX);
        else
            push_char(b);
    endfunction

    function automatic void length_or_convert(input logic [7:0] b, input logic [63:0] arg);
        if (b == ChLowL || (accept_upper_q && b == ChUpL))
            spec_phase = PhLong1;
        else
            convert_spec(b, arg);
    endfunction

    function automatic void predict_chars(input logic [7:0] b, input logic [63:0] arg);
        int before_size;
        before_size = expected_chars.size();
        if (b == ChNul)
        begin
            spec_phase = PhLiteral;
            return;
        end
        case (spec_phase)
            PhPercent:
            begin
                fill_q      = 8'd0;
                width_q     = 0;
                long_long_q = 1'b0;
                if (b == ChZero || b == ChSpace)
                begin
                    fill_q     = b;
                    spec_phase = PhWidth;
                end
                else
                    length_or_convert(b, arg);
            end
            PhWidth:
            begin
                if (b >= ChZero && b <= ChNine)
                begin
                    width_q = width_q * 10 + int'(b - ChZero);
                    if (width_q > MaxFieldWidth)
                        width_q = MaxFieldWidth;
                end
                else
                    length_or_convert(b, arg);
            end
            PhLong1:
            begin
                if (b == ChLowL)
                begin
                    long_long_q = 1'b1;
                    spec_phase  = PhLong2;
                end
                else
                    convert_spec(b, arg);
            end
            PhLong2:
                convert_spec(b, arg);
            default:
            begin
                if (b == ChPercent)
                    spec_phase = PhPercent;
                else
                    push_char(b);
            end
        endcase
        if (expected_chars.size() > before_size)
            expected_chars[expected_chars.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // random argument and conversion picks
    // ------------------------------------------------------------------------
    function automatic logic [63:0] random_arg();
        logic [63:0] small_val;
        small_val = 64'($urandom_range(999));
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return small_val;
            2: return -small_val;
            3: return {$urandom, $urandom};
            4:
            begin
                case ($urandom_range(5))
                    0: return 64'd0;
                    1: return '1;
                    2: return 64'h0000_0000_8000_0000;
                    3: return 64'h0000_0000_7FFF_FFFF;
                    4: return 64'h8000_0000_0000_0000;
                    default: return 64'hFFFF_FFFF_8000_0000;
                endcase
            end
            default: return {32'($urandom_range(1)) * 32'hFFFF_FFFF, $urandom};
        endcase
    endfunction

    function automatic logic [7:0] random_conv();
        logic [7:0] lower;
        case ($urandom_range(6))
            0: lower = ChLowC;
            1: lower = ChLowD;
            2: lower = ChLowI;
            3: lower = ChLowU;
            4: lower = ChLowX;
            5: lower = ChLowX;
            default: lower = ChLowS;
        endcase
        // now and then any byte, which mostly just echoes
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(1, 255));
        return ($urandom_range(3) == 0) ? lower - CaseOffset : lower;
    endfunction

    // ------------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------------

    // one fmt transaction; valid stays high into the next call unless a gap
    // is rolled, so back-to-back transactions never toggle it within a step
    task automatic send_fmt(input logic [7:0] b, input logic [63:0] arg);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            fmt_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        fmt_ch.valid    <= 1'b1;
        fmt_ch.fmt_byte <= b;
        fmt_ch.argument <= arg;
        do @(posedge clk); while (!fmt_ch.ready);
        predict_chars(b, arg);
        items_sent++;
    endtask

    // format text; the final byte carries the argument that matters
    task automatic send_text(input string text, input logic [63:0] arg);
        for (int i = 0; i < text.len(); i++)
            send_fmt(text[i], (i == text.len() - 1) ? arg : random_arg());
    endtask

    // both register writes back to back, valid held across them
    task automatic set_config(input logic hex_val, input logic accept_val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= RegHexUpper;
        cfg_ch.data  <= hex_val;
        do @(posedge clk); while (!cfg_ch.ready);
        hex_upper_q = hex_val;
        cfg_ch.index <= RegAcceptUpper;
        cfg_ch.data  <= accept_val;
        do @(posedge clk); while (!cfg_ch.ready);
        accept_upper_q = accept_val;
        cfg_ch.valid <= 1'b0;
    endtask

    // wait out every expected character, then let a silent conversion settle
    task automatic wait_drained();
        int waited;
        waited = 0;
        fmt_ch.valid <= 1'b0;
        while (expected_chars.size() != 0 && waited < DrainLimit)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_chars.size() != 0)
        begin
            $display("%0t: %0d expected characters never arrived", $time,
                     expected_chars.size());
            mismatch_count++;
            expected_chars.delete();
        end
        repeat (SettleCycles) @(posedge clk);
    endtask

    // one random specification: mostly well formed, some noise and breakage
    task automatic send_random_spec();
        int kind;
        int width_roll;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            send_fmt(ChPercent, random_arg());
            if ($urandom_range(1))
            begin
                send_fmt($urandom_range(1) ? ChZero : ChSpace, random_arg());
                width_roll = $urandom_range(19);
                if (width_roll < 12)
                    send_fmt(ChZero + 8'($urandom_range(9)), random_arg());
                else if (width_roll < 18)
                begin
                    send_fmt(ChZero + 8'($urandom_range(2)), random_arg());
                    send_fmt(ChZero + 8'($urandom_range(9)), random_arg());
                end
                else
                    // three digits can drive the width into saturation
                    repeat (3) send_fmt(ChZero + 8'($urandom_range(9)), random_arg());
            end
            case ($urandom_range(4))
                2: send_fmt($urandom_range(1) ? ChLowL : ChUpL, random_arg());
                3:
                begin
                    send_fmt(ChLowL, random_arg());
                    send_fmt(ChLowL, random_arg());
                end
                4:
                begin
                    send_fmt(ChUpL, random_arg());
                    send_fmt(ChLowL, random_arg());
                end
                default: ;
            endcase
            send_fmt(random_conv(), random_arg());
        end
        else if (kind < 82)
            send_fmt(8'($urandom_range(1, 255)), random_arg());
        else if (kind < 88)
            send_fmt(ChNul, random_arg());
        else
        begin
            // broken specification: interrupted by an arbitrary byte
            send_fmt(ChPercent, random_arg());
            if ($urandom_range(1))
                send_fmt(ChZero, random_arg());
            send_fmt(8'($urandom_range(255)), random_arg());
        end
    endtask

    // ------------------------------------------------------------------------
    // character checker and receiver ready
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && char_ch.valid && char_ch.ready)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected character, expected none, got char %h last %b",
                         $time, char_ch.out_char, char_ch.last);
                mismatch_count++;
            end
            else
            begin
                oldest_char = expected_chars.pop_front();
                if (char_ch.out_char !== oldest_char.ch)
                begin
                    $display("%0t: out_char expected %h got %h", $time, oldest_char.ch,
                             char_ch.out_char);
                    mismatch_count++;
                end
                if (char_ch.last !== oldest_char.last)
                begin
                    $display("%0t: last expected %b got %b", $time, oldest_char.last,
                             char_ch.last);
                    mismatch_count++;
                end
            end
        end
        // a long hold-off takes priority over the random stalls
        if (hold_left > 0)
        begin
            char_ch.ready <= 1'b0;
            hold_left--;
        end
        else
            char_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------------

    // plain bytes at both ends of the range and an escaped percent sign
    task automatic test_literal_text();
        send_fmt(8'h01, random_arg());
        send_fmt(8'hFF, random_arg());
        send_text("%%", random_arg());
    endtask

    // char, string, plain decimal and a single l that keeps 32 bits
    task automatic test_conversions();
        send_text("%c", 64'hA5A5_5A5A_0000_00FF);
        send_text("%s", random_arg());
        send_text("%i", 64'd0);
        send_text("%ld", 64'hFFFF_FFFF_8000_0000);
    endtask

    // width past the limit saturates; most negative 64-bit value fills all
    // 64 output slots with sign, zero fill and digits
    task automatic test_width_and_fill();
        send_text("%099lld", 64'h8000_0000_0000_0000);
        send_text("% 5x", 64'h0000_0000_0000_0ABC);
    endtask

    // a zero byte in the middle of a specification drops it
    task automatic test_terminator();
        send_text("%03", random_arg());
        send_fmt(ChNul, random_arg());
    endtask

    // random mix under one register setting and one idling pattern
    task automatic test_random_mix(input logic hex_val, input logic accept_val,
                                   input int sender_idle, input int receiver_stall,
                                   input int count);
        int target;
        wait_drained();
        set_config(hex_val, accept_val);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        target    = items_sent + count;
        while (items_sent < target)
            send_random_spec();
    endtask

    // receiver stops for a long stretch while wide conversions keep coming,
    // so the output register fills and the fmt channel backs up
    task automatic test_output_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 400;
        repeat (3)
        begin
            send_text("%063x", random_arg());
            send_fmt(8'($urandom_range(1, 255)), random_arg());
        end
        send_text("% 40u", random_arg());
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        fmt_ch.valid    = 1'b0;
        fmt_ch.fmt_byte = 8'd0;
        fmt_ch.argument = 64'd0;
        char_ch.ready   = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = RegHexUpper;
        cfg_ch.data     = 1'b0;

        spec_phase     = PhLiteral;
        fill_q         = 8'd0;
        width_q        = 0;
        long_long_q    = 1'b0;
        hex_upper_q    = 1'b1;
        accept_upper_q = 1'b1;
        mismatch_count = 0;
        items_sent     = 0;
        idle_pct       = 0;
        stall_pct      = 0;
        hold_left      = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset register values
        test_literal_text();
        test_conversions();
        test_width_and_fill();
        test_terminator();

        // register extremes crossed with the idling patterns
        test_random_mix(1'b1, 1'b1, 0, 0, 55);
        test_random_mix(1'b0, 1'b1, 61, 0, 55);
        test_random_mix(1'b1, 1'b0, 0, 61, 55);
        test_random_mix(1'b0, 1'b0, 20, 20, 55);

        test_output_backpressure();

        wait_drained();
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial
    begin
        #8000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
